### hdl/tblp_pkg.sv
// Shared types, constants and control encodings for the token bucket loss predictor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package tblp_pkg;

  localparam int TRACK_DEPTH_DEF = 64;
  localparam int TIME_BITS_DEF   = 48;

  localparam int COST_W  = 24;
  localparam int PKT_W   = 16;
  localparam int ID_W    = 32;
  localparam int CNT_W   = 32;
  localparam int PTIME_W = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_COST     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_PACKETS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_THRESHOLD = 2'd2;

  localparam logic [COST_W-1:0] TOKEN_COST_RST     = 24'd1000;
  localparam logic [PKT_W-1:0]  BUFFER_PACKETS_RST = 16'd64;
  localparam logic [PKT_W-1:0]  LOSS_THRESHOLD_RST = 16'd0;

  localparam logic ACT_SENT    = 1'b0;
  localparam logic ACT_REMOVED = 1'b1;

  localparam logic [16:0] DRAIN_CAP = 17'h10000;

  typedef struct packed {
    logic               action;
    logic [PTIME_W-1:0] packet_time;
    logic [ID_W-1:0]    packet_id;
    logic               declared_lost;
  } in_word_t;

  typedef struct packed {
    logic             predict_lost;
    logic [PKT_W-1:0] tokens_now;
    logic             table_full;
    logic             matched;
    logic [CNT_W-1:0] lost_count;
    logic [CNT_W-1:0] delivered_count;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic apply;
    logic pred;
    logic sweep_start;
    logic sweep_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic refill_need;
    logic div_done;
    logic need_lookup;
    logic sweep_done;
  } sts_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHK   = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_APPLY = 7'b0001000,
    ST_PRED  = 7'b0010000,
    ST_SWEEP = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

endpackage

### hdl/token_bucket_loss_predictor_top.sv
// Sequence per word: load, check, an optional bit-serial refill divide and apply, predict,
// an optional sweep of the tracking table, then finish; the result is registered after finish.
// A new word is taken only in idle; busy drops in the cycle of the result strobe.
// The bit-serial divider and the one-read-per-cycle table sweep are the slow steps.
// Reset (rst_n low, synchronous): registers to defaults, bucket and counters zero,
// table entries invalid. Results are strobed for one cycle and cannot be stalled.
`timescale 1ns / 1ps
module token_bucket_loss_predictor_top #(
  parameter int TRACK_DEPTH = tblp_pkg::TRACK_DEPTH_DEF,
  parameter int TIME_BITS   = tblp_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  tblp_pkg::in_word_t                in_word,
  output logic                              out_valid,
  output tblp_pkg::out_word_t               out_word,
  input  logic                              cfg_we,
  input  logic [tblp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tblp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tblp_pkg::cmd_t cmd;
  tblp_pkg::sts_t sts;

  tblp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  tblp_dp #(
    .TRACK_DEPTH (TRACK_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

### hdl/tblp_ctrl.sv
// Sequencing state machine for the token bucket loss predictor.
// Depends on tblp_pkg; drives commands to tblp_dp and reads its status.
`timescale 1ns / 1ps
module tblp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output tblp_pkg::cmd_t  cmd,
  input  tblp_pkg::sts_t  sts
);

  tblp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tblp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      tblp_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = tblp_pkg::ST_CHK;
        end
      end
      tblp_pkg::ST_CHK: begin
        if (sts.refill_need) begin
          cmd.div_start = 1'b1;
          state_nxt = tblp_pkg::ST_DIV;
        end else begin
          state_nxt = tblp_pkg::ST_PRED;
        end
      end
      tblp_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = tblp_pkg::ST_APPLY;
      end
      tblp_pkg::ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = tblp_pkg::ST_PRED;
      end
      tblp_pkg::ST_PRED: begin
        cmd.pred = 1'b1;
        if (sts.need_lookup) begin
          cmd.sweep_start = 1'b1;
          state_nxt = tblp_pkg::ST_SWEEP;
        end else begin
          state_nxt = tblp_pkg::ST_FIN;
        end
      end
      tblp_pkg::ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_done) state_nxt = tblp_pkg::ST_FIN;
      end
      tblp_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = tblp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tblp_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != tblp_pkg::ST_IDLE);

`ifndef SYNTHESIS
  a_div_from_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tblp_pkg::ST_DIV) |-> ($past(state_r) == tblp_pkg::ST_CHK ||
      $past(state_r) == tblp_pkg::ST_DIV))
    else $error("divide entered out of sequence");
  a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !busy)
    else $error("finish did not return to idle");
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy)
    else $error("load while busy");
`endif

endmodule

### hdl/tblp_dp.sv
// Datapath: config registers, bucket state, restoring divider, tracking table and counters.
// Depends on tblp_pkg; driven by commands from tblp_ctrl.
`timescale 1ns / 1ps
module tblp_dp #(
  parameter int TRACK_DEPTH = tblp_pkg::TRACK_DEPTH_DEF,
  parameter int TIME_BITS   = tblp_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tblp_pkg::in_word_t                in_word,
  input  logic                              cfg_we,
  input  logic [tblp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tblp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  tblp_pkg::cmd_t                    cmd,
  output tblp_pkg::sts_t                    sts,
  output logic                              out_valid,
  output tblp_pkg::out_word_t               out_word
);

  localparam int IW  = $clog2(TRACK_DEPTH);
  localparam int DCW = $clog2(TIME_BITS);
  localparam int CW  = tblp_pkg::COST_W;
  localparam int PW  = tblp_pkg::PKT_W;
  localparam logic [IW:0]     DEPTH_END = (IW+1)'(TRACK_DEPTH);
  localparam logic [DCW-1:0]  DIV_LAST  = DCW'(TIME_BITS - 1);

  logic [CW-1:0] cost_r;
  logic [PW-1:0] bufp_r, thr_r;

  logic                          act_r, dl_r;
  logic [TIME_BITS-1:0]          pt_r, bt_r;
  logic [tblp_pkg::ID_W-1:0]     id_r;
  logic [PW-1:0]                 tokens_r;
  logic [TIME_BITS-1:0]          quo_r;
  logic [CW:0]                   rem_r;
  logic [DCW-1:0]                div_cnt_r;
  logic                          predict_r;
  logic [IW:0]                   addr_r;
  logic [IW-1:0]                 cmp_idx_r, hit_idx_r, free_idx_r;
  logic                          cmp_vld_r, hit_r, free_found_r;
  logic [tblp_pkg::ID_W-1:0]     rd_data_r;
  logic [TRACK_DEPTH-1:0]        valid_r;
  logic [tblp_pkg::CNT_W-1:0]    lost_r, deliv_r;
  logic [tblp_pkg::CNT_W-1:0]    lost_nxt, deliv_nxt;
  logic                          out_valid_r;
  tblp_pkg::out_word_t           out_word_r;
  logic [tblp_pkg::ID_W-1:0]     mem [TRACK_DEPTH];

  logic [63:0]          pt64, bt64, diff64, cost64, quo64, newbt64;
  logic [TIME_BITS-1:0] pt_in;
  logic [CW-1:0]        cost_eff;
  logic [CW:0]          trial, trial_sub;
  logic [16:0]          drained;
  logic [17:0]          sum;
  logic [PW-1:0]        tok_out;
  logic                 mem_we;

  assign pt64     = 64'(in_word.packet_time);
  assign pt_in    = pt64[TIME_BITS-1:0];
  assign cost_eff = (cost_r == '0) ? CW'(1) : cost_r;
  assign bt64     = 64'(bt_r);
  assign diff64   = 64'(pt_r) - bt64;
  assign cost64   = 64'(cost_eff);

  assign sts.refill_need = (act_r == tblp_pkg::ACT_SENT) && (64'(pt_r) > bt64) &&
                           (diff64 > cost64);
  assign sts.div_done    = (div_cnt_r == DIV_LAST);
  assign sts.need_lookup = (act_r == tblp_pkg::ACT_REMOVED) || (tokens_r > thr_r);
  assign sts.sweep_done  = (addr_r == DEPTH_END);

  assign trial     = {rem_r[CW-1:0], quo_r[TIME_BITS-1]};
  assign trial_sub = trial - {1'b0, cost_eff};

  assign quo64   = 64'(quo_r);
  assign drained = (quo64 > 64'(tblp_pkg::DRAIN_CAP)) ? tblp_pkg::DRAIN_CAP : quo64[16:0];
  assign sum     = 18'(tokens_r) + 18'(drained);
  assign newbt64 = 64'(pt_r) - 64'(rem_r);

  assign tok_out   = ((act_r == tblp_pkg::ACT_SENT) && (tokens_r != '0)) ?
                     tokens_r - PW'(1) : tokens_r;
  assign lost_nxt  = ((act_r == tblp_pkg::ACT_REMOVED) && hit_r && dl_r && (lost_r != '1)) ?
                     lost_r + 32'd1 : lost_r;
  assign deliv_nxt = ((act_r == tblp_pkg::ACT_REMOVED) && hit_r && !dl_r &&
                      (deliv_r != '1)) ? deliv_r + 32'd1 : deliv_r;

  assign mem_we = cmd.finish && (act_r == tblp_pkg::ACT_SENT) && !predict_r && !hit_r &&
                  free_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r <= tblp_pkg::TOKEN_COST_RST;
      bufp_r <= tblp_pkg::BUFFER_PACKETS_RST;
      thr_r  <= tblp_pkg::LOSS_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tblp_pkg::CFG_TOKEN_COST:     cost_r <= cfg_data;
        tblp_pkg::CFG_BUFFER_PACKETS: bufp_r <= cfg_data[PW-1:0];
        tblp_pkg::CFG_LOSS_THRESHOLD: thr_r  <= cfg_data[PW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_word.action;
      dl_r  <= in_word.declared_lost;
      pt_r  <= pt_in;
      id_r  <= in_word.packet_id;
    end
    if (cmd.div_start) begin
      quo_r     <= diff64[TIME_BITS-1:0];
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, cost_eff}) begin
        rem_r <= trial_sub;
        quo_r <= {quo_r[TIME_BITS-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[TIME_BITS-2:0], 1'b0};
      end
      div_cnt_r <= div_cnt_r + DCW'(1);
    end
    if (cmd.pred) predict_r <= (act_r == tblp_pkg::ACT_SENT) && (tokens_r <= thr_r);
    if (cmd.sweep_start) begin
      addr_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.sweep_step) begin
      if (addr_r != DEPTH_END) begin
        cmp_idx_r <= addr_r[IW-1:0];
        cmp_vld_r <= 1'b1;
        addr_r    <= addr_r + (IW+1)'(1);
      end else begin
        cmp_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[addr_r[IW-1:0]];
    if (mem_we) mem[free_idx_r] <= id_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bt_r         <= '0;
      tokens_r     <= '0;
      valid_r      <= '0;
      lost_r       <= '0;
      deliv_r      <= '0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.load) begin
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
      end
      if (cmd.apply) begin
        bt_r     <= newbt64[TIME_BITS-1:0];
        tokens_r <= (sum < 18'(bufp_r)) ? sum[PW-1:0] : bufp_r;
      end
      if (cmd.sweep_step && cmp_vld_r) begin
        if (valid_r[cmp_idx_r] && (rd_data_r == id_r) && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= cmp_idx_r;
        end
        if (!valid_r[cmp_idx_r] && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= cmp_idx_r;
        end
      end
      if (cmd.finish) begin
        out_word_r.predict_lost <= predict_r;
        out_word_r.table_full   <= (act_r == tblp_pkg::ACT_SENT) && !predict_r && !hit_r &&
                                   !free_found_r;
        out_word_r.matched      <= (act_r == tblp_pkg::ACT_REMOVED) && hit_r;
        out_word_r.lost_count      <= lost_nxt;
        out_word_r.delivered_count <= deliv_nxt;
        out_word_r.tokens_now      <= tok_out;
        lost_r  <= lost_nxt;
        deliv_r <= deliv_nxt;
        if (act_r == tblp_pkg::ACT_SENT) begin
          if (mem_we) valid_r[free_idx_r] <= 1'b1;
          if (tokens_r != '0) begin
            if (tokens_r == bufp_r) bt_r <= pt_r;
            tokens_r <= tok_out;
          end else begin
            bt_r <= pt_r;
          end
        end else if (hit_r) begin
          valid_r[hit_idx_r] <= 1'b0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_insert_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !hit_r && !predict_r)
    else $error("insert of an id already tracked");
  a_refill_capped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> tokens_r <= bufp_r)
    else $error("refill above capacity");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");
  a_lost_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> lost_r >= $past(lost_r))
    else $error("lost counter decreased");
`endif

endmodule

### dv/tb_token_bucket_loss_predictor_top.sv
// Self-checking testbench for token_bucket_loss_predictor_top: directed and random words
// against a scoreboard that predicts the bucket, tracking table and loss counters.
// Depends on tblp_pkg and the token_bucket_loss_predictor_top RTL.
`timescale 1ns / 1ps
module tb_token_bucket_loss_predictor_top;
  import tblp_pkg::*;

  localparam int TRACK_N = TRACK_DEPTH_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  class loss_scoreboard;
    bit [COST_W-1:0]  token_cost;
    bit [PKT_W-1:0]   buffer_packets;
    bit [PKT_W-1:0]   loss_threshold;
    bit [PTIME_W-1:0] bkt_time;
    bit [PKT_W-1:0]   bkt_tokens;
    bit [ID_W-1:0]    ids [TRACK_N];
    bit               valid [TRACK_N];
    bit [CNT_W-1:0]   lost_total;
    bit [CNT_W-1:0]   delivered_total;
    out_word_t        pending[$];
    int               errors;

    function new();
      token_cost = TOKEN_COST_RST;
      buffer_packets = BUFFER_PACKETS_RST;
      loss_threshold = LOSS_THRESHOLD_RST;
      bkt_time = '0;
      bkt_tokens = '0;
      foreach (valid[i]) begin
        valid[i] = 0;
        ids[i] = '0;
      end
      lost_total = '0;
      delivered_total = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TOKEN_COST:     token_cost = data;
        CFG_BUFFER_PACKETS: buffer_packets = data[PKT_W-1:0];
        CFG_LOSS_THRESHOLD: loss_threshold = data[PKT_W-1:0];
        default: ;
      endcase
    endfunction

    function int find_id(bit [ID_W-1:0] id);
      for (int i = 0; i < TRACK_N; i++)
        if (valid[i] && ids[i] == id) return i;
      return -1;
    endfunction

    function void note_word(in_word_t w);
      out_word_t e;
      bit [63:0] cost;
      bit [63:0] pt;
      bit [63:0] drained;
      bit [63:0] sum;
      int slot;
      e = '0;
      if (w.action == ACT_SENT) begin
        pt = 64'(w.packet_time);
        cost = (token_cost == 0) ? 64'd1 : 64'(token_cost);
        if (pt > bkt_time && pt - bkt_time > cost) begin
          drained = (pt - bkt_time) / cost;
          bkt_time = PTIME_W'(64'(bkt_time) + cost * drained);
          if (drained > 64'h10000) drained = 64'h10000;
          sum = 64'(bkt_tokens) + drained;
          bkt_tokens = (sum < buffer_packets) ? sum[PKT_W-1:0] : buffer_packets;
        end
        e.predict_lost = (bkt_tokens <= loss_threshold);
        if (!e.predict_lost && find_id(w.packet_id) < 0) begin
          slot = -1;
          for (int i = TRACK_N - 1; i >= 0; i--)
            if (!valid[i]) slot = i;
          if (slot < 0) begin
            e.table_full = 1;
          end else begin
            ids[slot] = w.packet_id;
            valid[slot] = 1;
          end
        end
        if (bkt_tokens > 0) begin
          if (bkt_tokens == buffer_packets) bkt_time = pt[PTIME_W-1:0];
          bkt_tokens--;
        end else begin
          bkt_time = pt[PTIME_W-1:0];
        end
      end else begin
        slot = find_id(w.packet_id);
        if (slot >= 0) begin
          valid[slot] = 0;
          e.matched = 1;
          if (w.declared_lost) begin
            if (lost_total != '1) lost_total++;
          end else if (delivered_total != '1) begin
            delivered_total++;
          end
        end
      end
      e.tokens_now = bkt_tokens;
      e.lost_count = lost_total;
      e.delivered_count = delivered_total;
      pending.push_back(e);
    endfunction

    function void check_word(out_word_t a);
      out_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.predict_lost !== e.predict_lost) begin
        $error("predict_lost exp %0d got %0d", e.predict_lost, a.predict_lost);
        errors++;
      end
      if (a.tokens_now !== e.tokens_now) begin
        $error("tokens_now exp %0d got %0d", e.tokens_now, a.tokens_now);
        errors++;
      end
      if (a.table_full !== e.table_full) begin
        $error("table_full exp %0d got %0d", e.table_full, a.table_full);
        errors++;
      end
      if (a.matched !== e.matched) begin
        $error("matched exp %0d got %0d", e.matched, a.matched);
        errors++;
      end
      if (a.lost_count !== e.lost_count) begin
        $error("lost_count exp %0d got %0d", e.lost_count, a.lost_count);
        errors++;
      end
      if (a.delivered_count !== e.delivered_count) begin
        $error("delivered_count exp %0d got %0d", e.delivered_count, a.delivered_count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_word_t in_word;
  logic out_valid;
  out_word_t out_word;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  loss_scoreboard sb;
  longint unsigned cycles;
  bit [PTIME_W-1:0] now_ticks;
  int gap_left;

  token_bucket_loss_predictor_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(out_word);
  end

  // hold start until the word is taken; the burst caller lowers it
  task automatic send_word(in_word_t w);
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    sb.note_word(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  // the caller lowers cfg_we after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] cost, logic [PKT_W-1:0] bufp,
                          logic [PKT_W-1:0] thr);
    drain();
    write_reg(CFG_TOKEN_COST, cost);
    write_reg(CFG_BUFFER_PACKETS, bufp);
    write_reg(CFG_LOSS_THRESHOLD, thr);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_word_t make_word(logic act, bit [PTIME_W-1:0] t,
                                         bit [ID_W-1:0] id, logic lost);
    in_word_t w;
    w.action = act;
    w.packet_time = t;
    w.packet_id = id;
    w.declared_lost = lost;
    return w;
  endfunction

  // random word; times mostly advance in small steps relative to token cost
  function automatic in_word_t rand_word(int id_pool);
    bit [63:0] step;
    bit [ID_W-1:0] id;
    int r;
    r = $urandom_range(99);
    if (r < 88) begin
      step = 64'($urandom_range(3 * ((sb.token_cost == 0) ? 1 : sb.token_cost)));
      if (r < 2) step = {$urandom, $urandom} & 64'hFFFF_FFFF_FF;
      now_ticks = now_ticks + step[PTIME_W-1:0];
    end else if (r < 92) begin
      now_ticks = PTIME_W'({$urandom, $urandom});
    end
    id = ($urandom_range(19) == 0) ? $urandom : $urandom_range(id_pool - 1);
    return make_word(($urandom_range(9) < 6) ? ACT_SENT : ACT_REMOVED,
                     (r >= 92 && r < 95) ? PTIME_W'({$urandom, $urandom}) : now_ticks,
                     id, 1'($urandom_range(1)));
  endfunction

  task automatic random_phase(int n, int id_pool);
    int sent_n;
    sent_n = 0;
    while (sent_n < n) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        repeat (gap_left) @(posedge clk);
      end
      repeat ($urandom_range(12, 1)) begin
        if (sent_n < n) begin
          send_word(rand_word(id_pool));
          sent_n++;
        end
      end
      gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    now_ticks = '0;
    gap_left = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, refill, duplicates, removals, extremes
    send_word(make_word(ACT_SENT, 48'd0, 32'd0, 1'b0));
    send_word(make_word(ACT_SENT, 48'd1000, 32'd1, 1'b0));
    send_word(make_word(ACT_SENT, 48'd1001, 32'd2, 1'b0));
    send_word(make_word(ACT_SENT, 48'd50000, 32'hFFFF_FFFF, 1'b0));
    send_word(make_word(ACT_SENT, 48'd50001, 32'hFFFF_FFFF, 1'b0));
    send_word(make_word(ACT_REMOVED, 48'd0, 32'hFFFF_FFFF, 1'b1));
    send_word(make_word(ACT_REMOVED, 48'd0, 32'hFFFF_FFFF, 1'b0));
    send_word(make_word(ACT_SENT, 48'd60000, 32'd7, 1'b0));
    send_word(make_word(ACT_REMOVED, 48'hFFFF_FFFF_FFFF, 32'd7, 1'b0));
    send_word(make_word(ACT_SENT, 48'hFFFF_FFFF_FFFF, 32'hA5A5_5A5A, 1'b1));
    send_word(make_word(ACT_SENT, 48'd10, 32'd8, 1'b0));
    send_word(make_word(ACT_REMOVED, 48'd0, 32'hA5A5_5A5A, 1'b1));

    set_regs(24'd0, 16'd65535, 16'd0);
    write_reg(CFG_UNUSED, 24'hFFFFFF);
    cfg_we <= 1'b0;
    now_ticks = 48'd100;
    send_word(make_word(ACT_SENT, 48'd100, 32'd3, 1'b0));
    send_word(make_word(ACT_SENT, 48'd200, 32'd4, 1'b0));
    send_word(make_word(ACT_SENT, 48'h8000_0000_0000, 32'd5, 1'b0));
    set_regs(24'hFFFFFF, 16'd1, 16'd65535);
    send_word(make_word(ACT_SENT, 48'hFFFF_FFFF_FFFF, 32'd6, 1'b0));
    send_word(make_word(ACT_REMOVED, 48'd0, 32'd5, 1'b1));

    // fill the table past its depth
    set_regs(24'd1, 16'd65535, 16'd0);
    now_ticks = 48'd1_000_000;
    send_word(make_word(ACT_SENT, now_ticks, 32'd1000, 1'b0));
    for (int i = 0; i < TRACK_N + 4; i++) begin
      now_ticks = now_ticks + 48'd100;
      send_word(make_word(ACT_SENT, now_ticks, 32'(2000 + i), 1'b0));
    end

    // random phases across settings; tokens left above a lowered capacity
    set_regs(24'd5, 16'd200, 16'd0);
    random_phase(200, 90);
    set_regs(24'd5, 16'd4, 16'd1);
    random_phase(200, 90);
    set_regs(24'd7, 16'd8, 16'd2);
    random_phase(200, 80);
    set_regs(24'd0, 16'd64, 16'd0);
    random_phase(150, 120);
    set_regs(24'd50, 16'd64, 16'd0);
    random_phase(200, 100);
    set_regs(24'hFFFFFF, 16'd65535, 16'd65535);
    random_phase(100, 60);
    set_regs(24'd3, 16'd1, 16'd0);
    random_phase(150, 70);
    set_regs(24'd1000, 16'd64, 16'd0);
    random_phase(250, 100);

    drain();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
